// File: hdl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy allocator package
// Opcodes, status codes, sequencer states and unit command types.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGE_W   = 15;
	localparam int CNT_W    = 16;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 3;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;
	localparam int MARK_W   = 32;
	localparam int MARK_WB  = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_ADDREF = 2'd2,
		OP_SEED   = 2'd3
	} op_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_OOM   = 3'd1,
		ST_BOUND = 3'd2,
		ST_ZERO  = 3'd3,
		ST_REFD  = 3'd4,
		ST_SAT   = 3'd5
	} status_e_t;

	typedef enum logic {
		MK_QUERY = 1'b0,
		MK_SET   = 1'b1
	} mark_op_t;

	typedef enum logic {
		LS_PUSH   = 1'b0,
		LS_REMOVE = 1'b1
	} list_op_t;

	typedef struct packed {
		logic     go;
		mark_op_t op;
		logic     val;
	} mark_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} mark_rsp_t;

	typedef struct packed {
		logic     go;
		list_op_t op;
	} list_cmd_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_RD,
		M_MOD,
		M_FILL
	} mark_st_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_RD,
		L_W1,
		L_W2
	} list_st_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHK,
		S_SEEDQ,
		S_A_POP,
		S_A_MCLR,
		S_A_SPLIT,
		S_A_MSET,
		S_A_PUSH,
		S_A_CNT,
		S_R_TEST,
		S_R_REM,
		S_R_FIN,
		S_R_PUSH,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

// File: hdl/bpa_mark.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free page mark store
// One mark bit per page in 32-bit words; single-bit query, aligned block
// set/clear by read-modify-write or whole-word fill, self clear after reset.
// ----------------------------------------------------------------------------
module bpa_mark #(
	parameter int NUM_PAGES = 32768,
	parameter int TOP_ORDER = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bpa_pkg::mark_cmd_t               cmd,
	input  logic [$clog2(NUM_PAGES)-1:0]     page,
	input  logic [$clog2(TOP_ORDER+1)-1:0]   order,
	output bpa_pkg::mark_rsp_t               rsp
);
	import bpa_pkg::*;

	localparam int PW     = $clog2(NUM_PAGES);
	localparam int OW     = $clog2(TOP_ORDER + 1);
	localparam int MWORDS = (NUM_PAGES + MARK_W - 1) / MARK_W;
	localparam int MAW    = (MWORDS > 1) ? $clog2(MWORDS) : 1;
	localparam int CW     = ((MAW > TOP_ORDER) ? MAW : TOP_ORDER) + 1;

	logic [MARK_W-1:0] mem [MWORDS];

	mark_st_t            st_q, st_nx;
	mark_op_t            op_q;
	logic                val_q;
	logic [MAW:0]        addr_q;
	logic [CW-1:0]       left_q;
	logic [MARK_W-1:0]   mask_q;
	logic [MARK_W-1:0]   rd_q;
	logic [MARK_WB-1:0]  bit_q;

	logic [PW+MARK_WB-1:0] pe;
	logic [OW+MARK_WB:0]   oe;
	logic                  sub_word;
	logic [MARK_W-1:0]     lowmask;
	logic                  fill_last;

	assign pe        = (PW + MARK_WB)'(page);
	assign oe        = (OW + MARK_WB + 1)'(order);
	assign sub_word  = oe < (OW + MARK_WB + 1)'(MARK_WB);
	assign lowmask   = ~({MARK_W{1'b1}} << (MARK_W'(1) << oe[MARK_WB-1:0]));
	assign fill_last = left_q == CW'(1);

	always_comb begin
		st_nx = st_q;
		case (st_q)
			M_IDLE: begin
				if (cmd.go) begin
					st_nx = (cmd.op == MK_QUERY || sub_word) ? M_RD : M_FILL;
				end
			end
			M_RD:   st_nx = M_MOD;
			M_MOD:  st_nx = M_IDLE;
			M_FILL: begin
				if (fill_last) begin
					st_nx = M_IDLE;
				end
			end
			default: st_nx = M_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = st_q != M_IDLE;
		rsp.done = (st_q == M_MOD) || (st_q == M_FILL && fill_last);
		rsp.hit  = rd_q[bit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_FILL;
			op_q   <= MK_SET;
			val_q  <= 1'b0;
			addr_q <= '0;
			left_q <= CW'(MWORDS);
			mask_q <= '0;
			bit_q  <= '0;
		end else begin
			st_q <= st_nx;
			case (st_q)
				M_IDLE: begin
					if (cmd.go) begin
						op_q   <= cmd.op;
						val_q  <= cmd.val;
						addr_q <= (MAW + 1)'(pe[PW+MARK_WB-1:MARK_WB]);
						bit_q  <= pe[MARK_WB-1:0];
						mask_q <= lowmask << pe[MARK_WB-1:0];
						left_q <= sub_word ? CW'(1) : (CW'(1) << (oe - MARK_WB));
					end
				end
				M_FILL: begin
					addr_q <= addr_q + 1'b1;
					left_q <= left_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == M_RD) begin
			rd_q <= mem[addr_q[MAW-1:0]];
		end
		if (st_q == M_MOD && op_q == MK_SET) begin
			mem[addr_q[MAW-1:0]] <= val_q ? (rd_q | mask_q) : (rd_q & ~mask_q);
		end else if (st_q == M_FILL && addr_q < (MAW + 1)'(MWORDS)) begin
			mem[addr_q[MAW-1:0]] <= {MARK_W{val_q}};
		end
	end

endmodule
`default_nettype wire

// File: hdl/bpa_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-order free lists
// Circular doubly linked lists in next/prev link memories with one head
// per order; push at head and removal of any member.
// ----------------------------------------------------------------------------
module bpa_list #(
	parameter int NUM_PAGES = 32768,
	parameter int TOP_ORDER = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bpa_pkg::list_cmd_t               cmd,
	input  logic [$clog2(TOP_ORDER+1)-1:0]   order,
	input  logic [$clog2(NUM_PAGES)-1:0]     page,
	output logic                             done,
	output logic [TOP_ORDER:0]               nonempty,
	output logic [$clog2(NUM_PAGES)-1:0]     head
);
	import bpa_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int OW = $clog2(TOP_ORDER + 1);

	logic [PW-1:0] next_mem [NUM_PAGES];
	logic [PW-1:0] prev_mem [NUM_PAGES];
	logic [PW-1:0] head_q [TOP_ORDER+1];
	logic [TOP_ORDER:0] hv_q;

	list_st_t      st_q, st_nx;
	list_op_t      op_q;
	logic [PW-1:0] p_q, h_q, nx_q, pv_q;
	logic [OW-1:0] o_q;
	logic          emp_q;

	logic          nwe, pwe;
	logic [PW-1:0] nwa, nwd, pwa, pwd;
	logic          push_long;

	assign nonempty  = hv_q;
	assign head      = head_q[order];
	assign push_long = op_q == LS_PUSH && !emp_q;

	always_comb begin
		st_nx = st_q;
		case (st_q)
			L_IDLE: begin
				if (cmd.go) begin
					st_nx = (cmd.op == LS_PUSH && !hv_q[order]) ? L_W1 : L_RD;
				end
			end
			L_RD: st_nx = L_W1;
			L_W1: st_nx = push_long ? L_W2 : L_IDLE;
			L_W2: st_nx = L_IDLE;
			default: st_nx = L_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == L_W1 && !push_long) || st_q == L_W2;
		nwe  = 1'b0;
		pwe  = 1'b0;
		nwa  = p_q;
		nwd  = p_q;
		pwa  = p_q;
		pwd  = p_q;
		case (st_q)
			L_W1: begin
				if (op_q == LS_PUSH) begin
					nwe = 1'b1;
					pwe = 1'b1;
					nwd = emp_q ? p_q : h_q;
					pwd = emp_q ? p_q : pv_q;
				end else if (nx_q != p_q) begin
					nwe = 1'b1;
					pwe = 1'b1;
					nwa = pv_q;
					nwd = nx_q;
					pwa = nx_q;
					pwd = pv_q;
				end
			end
			L_W2: begin
				nwe = 1'b1;
				pwe = 1'b1;
				nwa = pv_q;
				pwa = h_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= L_IDLE;
			hv_q  <= '0;
			op_q  <= LS_PUSH;
			emp_q <= 1'b0;
			o_q   <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == L_IDLE && cmd.go) begin
				op_q  <= cmd.op;
				emp_q <= !hv_q[order];
				o_q   <= order;
			end
			if (st_q == L_W1) begin
				if (op_q == LS_PUSH && emp_q) begin
					hv_q[o_q] <= 1'b1;
				end else if (op_q == LS_REMOVE && nx_q == p_q) begin
					hv_q[o_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == L_IDLE && cmd.go) begin
			p_q <= page;
			h_q <= head_q[order];
		end
		if (st_q == L_RD) begin
			nx_q <= next_mem[(op_q == LS_PUSH) ? h_q : p_q];
			pv_q <= prev_mem[(op_q == LS_PUSH) ? h_q : p_q];
		end
		if (st_q == L_W1) begin
			if (op_q == LS_PUSH && emp_q) begin
				head_q[o_q] <= p_q;
			end else if (op_q == LS_REMOVE && nx_q != p_q && hv_q[o_q] && h_q == p_q) begin
				head_q[o_q] <= nx_q;
			end
		end
		if (st_q == L_W2) begin
			head_q[o_q] <= p_q;
		end
		if (nwe) begin
			next_mem[nwa] <= nwd;
		end
		if (pwe) begin
			prev_mem[pwa] <= pwd;
		end
	end

endmodule
`default_nettype wire

// File: hdl/buddy_page_allocator_refcount.sv
`timescale 1ns / 1ps
`default_nettype none
// Allocate out of memory, add-ref, bound rejects and free to nonzero skip the units.
// Allocate and release walk one order at a time through the list and mark units;
// mark updates of big blocks are whole-word fills of 2^(order-5) words.
// One request at a time; the next beat is taken once the result is queued.
// After reset a clearing pass over every page zeroes counts and marks;
// no request is taken during it.
// ----------------------------------------------------------------------------
// Buddy page allocator with reference counts
// Sequencer over a count memory, a mark store and per-order free lists.
// ----------------------------------------------------------------------------
module buddy_page_allocator_refcount #(
	parameter int NUM_PAGES = 32768,
	parameter int TOP_ORDER = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::PAGE_W-1:0]     cfg_wdata,   // lowest_usable_page
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bpa_pkg::S_DATA_W-1:0]   s_tdata,     // opcode, page_index
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bpa_pkg::M_DATA_W-1:0]   m_tdata      // status, result_page, ref_count
);
	import bpa_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int OW = $clog2(TOP_ORDER + 1);
	localparam int BW = ((PW > TOP_ORDER) ? PW : TOP_ORDER) + 1;
	localparam int XW = BW + PAGE_W;

	logic [CNT_W-1:0] cnt_mem [NUM_PAGES];
	logic [OW-1:0]    ord_mem [NUM_PAGES];

	state_t            st_q, st_nx;
	logic              issued_q;
	logic              m_tvalid_q;
	logic [PW-1:0]     clr_q;
	logic [PAGE_W-1:0] low_q;

	op_e_t             op_q;
	logic [PAGE_W-1:0] pg_q;
	logic [PW-1:0]     pga_q, p_q, b_q, idx_q;
	logic [OW-1:0]     o_q;
	status_e_t         status_q;
	logic [PAGE_W-1:0] rpage_q;
	logic [CNT_W-1:0]  cnt_q, cnt_rd_q;
	logic [OW-1:0]     ord_rd_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	op_e_t             in_op;
	logic [PAGE_W-1:0] in_pg;
	logic [PW-1:0]     in_pga;
	logic              in_oor;
	logic              accept;

	mark_cmd_t         mk_cmd;
	mark_rsp_t         mk_rsp;
	logic [PW-1:0]     mk_page;
	list_cmd_t         ls_cmd;
	logic              ls_done;
	logic [PW-1:0]     ls_page;
	logic [TOP_ORDER:0] ls_nonempty;
	logic [PW-1:0]     ls_head;

	logic              any_free;
	logic [OW-1:0]     enc;
	logic [CNT_W-1:0]  cnt_nx;
	logic              chk_bound, chk_add_ok, chk_free_ok;
	logic [BW-1:0]     bw, bsum;
	logic              r_stop;
	logic              call_done, issue;
	logic              cnt_we, ord_we;
	logic [PW-1:0]     cnt_wa, ord_wa;
	logic [CNT_W-1:0]  cnt_wd;
	logic [OW-1:0]     ord_wd;
	logic              out_load;
	logic [XW-1:0]     p_ext;

	assign in_op    = op_e_t'(s_tdata[OP_W-1:0]);
	assign in_pg    = s_tdata[OP_W+PAGE_W-1:OP_W];
	assign in_pga   = PW'(XW'(in_pg));
	assign in_oor   = XW'(in_pg) >= XW'(NUM_PAGES);
	assign s_tready = st_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_load = st_q == S_OUT && (!m_tvalid_q || m_tready);

	always_comb begin
		enc = '0;
		for (int i = TOP_ORDER; i >= 0; i--) begin
			if (ls_nonempty[i]) begin
				enc = OW'(i);
			end
		end
	end
	assign any_free = |ls_nonempty;

	assign cnt_nx      = (op_q == OP_ADDREF) ? cnt_rd_q + 1'b1 : cnt_rd_q - 1'b1;
	assign chk_bound   = op_q != OP_ADDREF && pg_q < low_q;
	assign chk_add_ok  = op_q == OP_ADDREF && cnt_rd_q != '0 && cnt_rd_q != CNT_MAX;
	assign chk_free_ok = op_q == OP_FREE && !chk_bound && cnt_rd_q != '0;

	assign bw     = BW'(idx_q) ^ (BW'(1) << o_q);
	assign r_stop = o_q == OW'(TOP_ORDER) || bw >= BW'(NUM_PAGES);
	assign bsum   = BW'(p_q) + (BW'(1) << (o_q - 1'b1));
	assign p_ext  = XW'(p_q);

	always_comb begin
		case (st_q)
			S_SEEDQ, S_A_MCLR, S_A_MSET, S_R_TEST, S_R_FIN: call_done = mk_rsp.done;
			S_A_POP, S_A_PUSH, S_R_REM, S_R_PUSH:          call_done = ls_done;
			default:                                       call_done = 1'b0;
		endcase
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			S_CLEAR: begin
				if (clr_q == PW'(NUM_PAGES - 1) && !mk_rsp.busy) begin
					st_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_ALLOC) begin
						st_nx = any_free ? S_A_POP : S_OUT;
					end else begin
						st_nx = in_oor ? S_OUT : S_CHK;
					end
				end
			end
			S_CHK: begin
				if (op_q == OP_ADDREF || chk_bound) begin
					st_nx = S_OUT;
				end else if (op_q == OP_FREE) begin
					st_nx = (chk_free_ok && cnt_nx == '0) ? S_R_TEST : S_OUT;
				end else begin
					st_nx = (cnt_rd_q != '0) ? S_OUT : S_SEEDQ;
				end
			end
			S_SEEDQ: begin
				if (call_done) begin
					st_nx = mk_rsp.hit ? S_OUT : S_R_TEST;
				end
			end
			S_A_POP: begin
				if (call_done) begin
					st_nx = S_A_MCLR;
				end
			end
			S_A_MCLR: begin
				if (call_done) begin
					st_nx = S_A_SPLIT;
				end
			end
			S_A_SPLIT: st_nx = (o_q == '0) ? S_A_CNT : S_A_MSET;
			S_A_MSET: begin
				if (call_done) begin
					st_nx = S_A_PUSH;
				end
			end
			S_A_PUSH: begin
				if (call_done) begin
					st_nx = S_A_SPLIT;
				end
			end
			S_A_CNT: st_nx = S_OUT;
			S_R_TEST: begin
				if (r_stop) begin
					st_nx = S_R_FIN;
				end else if (call_done) begin
					st_nx = (mk_rsp.hit && ord_rd_q == o_q) ? S_R_REM : S_R_FIN;
				end
			end
			S_R_REM: begin
				if (call_done) begin
					st_nx = S_R_TEST;
				end
			end
			S_R_FIN: begin
				if (call_done) begin
					st_nx = S_R_PUSH;
				end
			end
			S_R_PUSH: begin
				if (call_done) begin
					st_nx = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) begin
					st_nx = S_IDLE;
				end
			end
			default: st_nx = S_IDLE;
		endcase
	end

	always_comb begin
		issue   = !issued_q;
		mk_cmd  = '{go: 1'b0, op: MK_SET, val: 1'b1};
		mk_page = idx_q;
		ls_cmd  = '{go: 1'b0, op: LS_PUSH};
		ls_page = idx_q;
		cnt_we  = 1'b0;
		cnt_wa  = pga_q;
		cnt_wd  = cnt_nx;
		ord_we  = 1'b0;
		ord_wa  = idx_q;
		ord_wd  = o_q;
		case (st_q)
			S_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wa = clr_q;
				cnt_wd = '0;
				ord_we = 1'b1;
				ord_wa = clr_q;
				ord_wd = '0;
			end
			S_CHK: cnt_we = chk_add_ok || chk_free_ok;
			S_SEEDQ: begin
				mk_cmd  = '{go: issue, op: MK_QUERY, val: 1'b0};
				mk_page = pga_q;
			end
			S_A_POP: begin
				ls_cmd  = '{go: issue, op: LS_REMOVE};
				ls_page = ls_head;
			end
			S_A_MCLR: begin
				mk_cmd  = '{go: issue, op: MK_SET, val: 1'b0};
				mk_page = p_q;
			end
			S_A_MSET: begin
				mk_cmd  = '{go: issue, op: MK_SET, val: 1'b1};
				mk_page = b_q;
				ord_we  = issue;
				ord_wa  = b_q;
			end
			S_A_PUSH: begin
				ls_cmd  = '{go: issue, op: LS_PUSH};
				ls_page = b_q;
			end
			S_A_CNT: begin
				cnt_we = 1'b1;
				cnt_wa = p_q;
				cnt_wd = CNT_W'(1);
			end
			S_R_TEST: begin
				mk_cmd  = '{go: issue && !r_stop, op: MK_QUERY, val: 1'b0};
				mk_page = bw[PW-1:0];
			end
			S_R_REM: begin
				ls_cmd  = '{go: issue, op: LS_REMOVE};
				ls_page = b_q;
			end
			S_R_FIN: begin
				mk_cmd = '{go: issue, op: MK_SET, val: 1'b1};
				ord_we = issue;
			end
			S_R_PUSH: ls_cmd = '{go: issue, op: LS_PUSH};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_CLEAR;
			issued_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			clr_q      <= '0;
			low_q      <= '0;
		end else begin
			st_q <= st_nx;
			if (mk_cmd.go || ls_cmd.go) begin
				issued_q <= 1'b1;
			end else if (call_done) begin
				issued_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (st_q == S_CLEAR && clr_q != PW'(NUM_PAGES - 1)) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				low_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= in_op;
					pg_q     <= in_pg;
					pga_q    <= in_pga;
					rpage_q  <= in_pg;
					cnt_q    <= '0;
					o_q      <= enc;
					status_q <= ST_OK;
					if (in_op == OP_ALLOC) begin
						if (!any_free) begin
							status_q <= ST_OOM;
						end
					end else if (in_oor) begin
						status_q <= ST_BOUND;
					end
				end
			end
			S_CHK: begin
				idx_q <= pga_q;
				o_q   <= '0;
				if (op_q == OP_ADDREF) begin
					cnt_q <= chk_add_ok ? cnt_nx : cnt_rd_q;
					if (cnt_rd_q == '0) begin
						status_q <= ST_ZERO;
					end else if (cnt_rd_q == CNT_MAX) begin
						status_q <= ST_SAT;
					end
				end else if (chk_bound) begin
					status_q <= ST_BOUND;
					cnt_q    <= cnt_rd_q;
				end else if (op_q == OP_FREE) begin
					if (cnt_rd_q == '0) begin
						status_q <= ST_ZERO;
					end else begin
						cnt_q <= cnt_nx;
						if (cnt_nx != '0) begin
							status_q <= ST_REFD;
						end
					end
				end else if (cnt_rd_q != '0) begin
					status_q <= ST_REFD;
					cnt_q    <= cnt_rd_q;
				end
			end
			S_A_POP: begin
				if (issue) begin
					p_q <= ls_head;
				end
			end
			S_A_SPLIT: begin
				if (o_q != '0) begin
					o_q <= o_q - 1'b1;
					b_q <= bsum[PW-1:0];
				end
			end
			S_A_CNT: begin
				rpage_q <= p_ext[PAGE_W-1:0];
				cnt_q   <= CNT_W'(1);
			end
			S_R_TEST: begin
				if (issue && !r_stop) begin
					b_q <= bw[PW-1:0];
				end
			end
			S_R_REM: begin
				if (call_done) begin
					idx_q <= (b_q < idx_q) ? b_q : idx_q;
					o_q   <= o_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= M_DATA_W'({cnt_q, rpage_q, status_q});
		end
		if (accept) begin
			cnt_rd_q <= cnt_mem[in_pga];
		end
		if (st_q == S_R_TEST && issue && !r_stop) begin
			ord_rd_q <= ord_mem[bw[PW-1:0]];
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
	end

	bpa_mark #(
		.NUM_PAGES (NUM_PAGES),
		.TOP_ORDER (TOP_ORDER)
	) u_mark (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mk_cmd),
		.page   (mk_page),
		.order  (o_q),
		.rsp    (mk_rsp)
	);

	bpa_list #(
		.NUM_PAGES (NUM_PAGES),
		.TOP_ORDER (TOP_ORDER)
	) u_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ls_cmd),
		.order    (o_q),
		.page     (ls_page),
		.done     (ls_done),
		.nonempty (ls_nonempty),
		.head     (ls_head)
	);

endmodule
`default_nettype wire

// File: sim/tb_buddy_page_allocator_refcount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives alloc, free, add-ref and seed beats over the stream ports, predicts
// every result with an in-bench buddy/refcount model, compares field by field.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator_refcount;
	import bpa_pkg::*;

	localparam int NPAGES     = 32768;
	localparam int TOP        = 15;
	localparam int HOLD_CYC   = 3000;
	localparam int STALL_LIMIT = 300000;

	typedef struct {
		status_e_t        st;
		logic [PAGE_W-1:0] pg;
		logic [CNT_W-1:0]  cnt;
	} alloc_result_t;

	class allocator_scoreboard;
		bit [CNT_W-1:0] counts[NPAGES];
		bit             free_mark[NPAGES];
		int             blk_order[NPAGES];
		int             nxt[NPAGES];
		int             prv[NPAGES];
		int             head[TOP+1];
		int             lowest;
		int             live[$];
		alloc_result_t  expected[$];
		int             errors;

		function new();
			for (int o = 0; o <= TOP; o++) head[o] = -1;
			lowest = 0;
			errors = 0;
		endfunction

		function void mark_block(int start, int o, bit v);
			for (int i = 0; i < (1 << o); i++)
				if (start + i < NPAGES) free_mark[start + i] = v;
		endfunction

		function void push(int o, int p);
			int h, t;
			h = head[o];
			if (h < 0) begin
				nxt[p] = p;
				prv[p] = p;
			end else begin
				t = prv[h];
				nxt[p] = h;
				prv[p] = t;
				nxt[t] = p;
				prv[h] = p;
			end
			head[o] = p;
		endfunction

		function void unlink(int o, int p);
			int n, q;
			n = nxt[p];
			q = prv[p];
			if (n == p) begin
				head[o] = -1;
				return;
			end
			nxt[q] = n;
			prv[n] = q;
			if (head[o] == p) head[o] = n;
		endfunction

		function void merge_and_free(int idx);
			int o, b;
			o = 0;
			while (o < TOP) begin
				b = idx ^ (1 << o);
				if (!free_mark[b] || blk_order[b] != o) break;
				unlink(o, b);
				if (b < idx) idx = b;
				o++;
			end
			mark_block(idx, o, 1'b1);
			blk_order[idx] = o;
			push(o, idx);
		endfunction

		function void note(op_e_t op, int pg);
			alloc_result_t r;
			int o, p, b, li;
			r.st  = ST_OK;
			r.pg  = pg[PAGE_W-1:0];
			r.cnt = '0;
			case (op)
				OP_ALLOC: begin
					o = 0;
					while (o <= TOP && head[o] < 0) o++;
					if (o > TOP) begin
						r.st = ST_OOM;
					end else begin
						p = head[o];
						unlink(o, p);
						mark_block(p, o, 1'b0);
						while (o > 0) begin
							o--;
							b = p + (1 << o);
							mark_block(b, o, 1'b1);
							blk_order[b] = o;
							push(o, b);
						end
						counts[p] = CNT_W'(1);
						r.pg  = p[PAGE_W-1:0];
						r.cnt = CNT_W'(1);
						live.push_back(p);
					end
				end
				OP_ADDREF: begin
					r.cnt = counts[pg];
					if (r.cnt == 0) r.st = ST_ZERO;
					else if (r.cnt == CNT_MAX) r.st = ST_SAT;
					else begin
						r.cnt = r.cnt + 1'b1;
						counts[pg] = r.cnt;
					end
				end
				default: begin
					r.cnt = counts[pg];
					if (pg < lowest) begin
						r.st = ST_BOUND;
					end else if (op == OP_FREE) begin
						if (r.cnt == 0) begin
							r.st = ST_ZERO;
						end else begin
							r.cnt = r.cnt - 1'b1;
							counts[pg] = r.cnt;
							if (r.cnt > 0) r.st = ST_REFD;
							else begin
								merge_and_free(pg);
								for (li = 0; li < live.size(); li++)
									if (live[li] == pg) begin
										live.delete(li);
										break;
									end
							end
						end
					end else begin
						if (r.cnt != 0) r.st = ST_REFD;
						else if (!free_mark[pg]) merge_and_free(pg);
					end
				end
			endcase
			expected.push_back(r);
		endfunction

		function void check(logic [M_DATA_W-1:0] d);
			alloc_result_t e;
			if (expected.size() == 0) begin
				$error("result beat with nothing expected: %h", d);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (d[2:0] !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, d[2:0]);
				errors++;
			end
			if (d[17:3] !== e.pg) begin
				$error("result_page: expected %0d, actual %0d", e.pg, d[17:3]);
				errors++;
			end
			if (d[33:18] !== e.cnt) begin
				$error("ref_count: expected %0d, actual %0d", e.cnt, d[33:18]);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [PAGE_W-1:0]   cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	allocator_scoreboard sb;
	int snd_idle_pct;
	int rcv_stall_pct;
	int hold_asked;
	int hold_done;
	int hold_left;
	int quiet_cycles;
	int seed_cursor;

	buddy_page_allocator_refcount uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check, random stall, long hold on request
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check(m_tdata);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_asked != hold_done) begin
			hold_done <= hold_asked;
			hold_left <= HOLD_CYC;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(op_e_t op, int pg);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W-PAGE_W-OP_W){1'b0}}, pg[PAGE_W-1:0], op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note(op, pg);
		if ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_lowest(int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[PAGE_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.lowest = v;
	endtask

	function automatic int live_page();
		if (sb.live.size() == 0) return $urandom_range(NPAGES - 1);
		return sb.live[$urandom_range(sb.live.size() - 1)];
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 30) send(OP_ALLOC, $urandom_range(NPAGES - 1));
		else if (r < 55) send(OP_FREE, live_page());
		else if (r < 65) send(OP_ADDREF, live_page());
		else if (r < 80) begin
			send(OP_SEED, seed_cursor);
			seed_cursor = (seed_cursor + 1) % NPAGES;
		end else if (r < 90) send(OP_FREE, $urandom_range(NPAGES - 1));
		else send(op_e_t'($urandom_range(3)), $urandom_range(NPAGES - 1));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_asked = 0;
		hold_done = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_lowest(0);

		// directed: empty pool, zero counts, seed twice, split, refs, merge
		send(OP_ALLOC, 0);
		send(OP_FREE, 0);
		send(OP_ADDREF, 5);
		send(OP_SEED, 32767);
		send(OP_SEED, 32767);
		send(OP_SEED, 32766);
		send(OP_ALLOC, 32767);
		send(OP_ADDREF, 32766);
		send(OP_SEED, 32766);
		send(OP_FREE, 32766);
		send(OP_FREE, 32766);
		send(OP_FREE, 32766);
		send(OP_SEED, 1000);
		send(OP_ALLOC, 0);
		// repeated references to page 1000
		repeat (20) send(OP_ADDREF, 1000);
		send(OP_ADDREF, 1000);
		drain();
		write_lowest(32767);
		send(OP_FREE, 1000);
		send(OP_SEED, 5);
		send(OP_FREE, 32767);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 87; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 87; end
				default: begin snd_idle_pct = 37; rcv_stall_pct = 37; end
			endcase
			write_lowest(ph == 1 ? $urandom_range(1, 4000) : 0);
			seed_cursor = $urandom_range(NPAGES - 1) & ~255;
			for (int i = 0; i < 340; i++) begin
				if (ph == 0 && i == 100) hold_asked++;
				random_item();
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: buddy_page_allocator_refcount.f
hdl/bpa_pkg.sv
hdl/bpa_mark.sv
hdl/bpa_list.sv
hdl/buddy_page_allocator_refcount.sv
sim/tb_buddy_page_allocator_refcount.sv
